@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the scheduler RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define WCPS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define WCPS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define WCPS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/wcps_pkg.sv @@
// ---------------------------------------------------------------------------
// wcps_pkg
// Types, codes and sizing for the weighted class packet scheduler.
// ---------------------------------------------------------------------------
package wcps_pkg;

  localparam int QUEUE_DEPTH  = 64;
  localparam int HANDLE_WIDTH = 16;
  localparam int NUM_QUEUES   = 7;
  localparam int NUM_CLASSES  = 6;

  localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TOT_W       = $clog2(STORE_DEPTH + 1);

  localparam int PORT_HANDLE_W = 16;
  localparam int PORT_TOTAL_W  = 9;
  localparam int HND_WIDE_W    = (HANDLE_WIDTH > PORT_HANDLE_W) ? HANDLE_WIDTH : PORT_HANDLE_W;
  localparam int TOT_WIDE_W    = (TOT_W > PORT_TOTAL_W) ? TOT_W : PORT_TOTAL_W;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [2:0] REG_WEIGHT_PUSH      = 3'd0;
  localparam logic [2:0] REG_WEIGHT_QUERY_HIT = 3'd1;
  localparam logic [2:0] REG_WEIGHT_QUERY     = 3'd2;
  localparam logic [2:0] REG_WEIGHT_PONG      = 3'd3;
  localparam logic [2:0] REG_WEIGHT_PING      = 3'd4;
  localparam logic [2:0] REG_WEIGHT_MISC      = 3'd5;

  localparam logic [3:0] WEIGHT_RESET [NUM_CLASSES] = '{
    4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd1
  };

  // Commands
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_SEND    = 1'b1;

  // Message kinds
  localparam logic [3:0] KIND_PING       = 4'd0;
  localparam logic [3:0] KIND_PONG       = 4'd1;
  localparam logic [3:0] KIND_BYE        = 4'd2;
  localparam logic [3:0] KIND_ROUTE      = 4'd3;
  localparam logic [3:0] KIND_VENDOR     = 4'd4;
  localparam logic [3:0] KIND_VENDOR_STD = 4'd5;
  localparam logic [3:0] KIND_PUSH       = 4'd6;
  localparam logic [3:0] KIND_QUERY      = 4'd7;
  localparam logic [3:0] KIND_HIT        = 4'd8;

  // Queue numbers
  localparam logic [2:0] Q_URGENT    = 3'd0;
  localparam logic [2:0] Q_PUSH      = 3'd1;
  localparam logic [2:0] Q_QUERY_HIT = 3'd2;
  localparam logic [2:0] Q_QUERY     = 3'd3;
  localparam logic [2:0] Q_PONG      = 3'd4;
  localparam logic [2:0] Q_PING      = 3'd5;
  localparam logic [2:0] Q_MISC      = 3'd6;

  // Result status
  localparam logic [2:0] ST_ENQUEUED = 3'd0;
  localparam logic [2:0] ST_SENT     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd4;

  typedef struct packed {
    logic       cmd;
    logic [3:0] msg_kind;
    logic [7:0] ttl;
    logic [7:0] hops;
    logic [15:0] packet_handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  queue_number;
    logic [15:0] handle_out;
    logic [8:0]  packets_waiting;
  } out_item_t;

  function automatic logic [HANDLE_WIDTH-1:0] hnd_from_port(logic [PORT_HANDLE_W-1:0] h);
    logic [HND_WIDE_W-1:0] w;
    w = '0;
    w[PORT_HANDLE_W-1:0] = h;
    return w[HANDLE_WIDTH-1:0];
  endfunction

  function automatic logic [PORT_HANDLE_W-1:0] hnd_to_port(logic [HANDLE_WIDTH-1:0] h);
    logic [HND_WIDE_W-1:0] w;
    w = '0;
    w[HANDLE_WIDTH-1:0] = h;
    return w[PORT_HANDLE_W-1:0];
  endfunction

  function automatic logic [PORT_TOTAL_W-1:0] tot_to_port(logic [TOT_W-1:0] t);
    logic [TOT_WIDE_W-1:0] w;
    w = '0;
    w[TOT_W-1:0] = t;
    return w[PORT_TOTAL_W-1:0];
  endfunction

endpackage

@@ rtl/core/weighted_class_packet_scheduler_unit.sv @@
// An accepted item is decided into the decision register, then moves to the
//   output register, which is fed by the handle store's registered read.
// Throughput: one item per cycle; a stalled output holds one result and one
//   decided item, after which the input stalls.
// Reset (synchronous): all queues empty, credits and weights at reset values;
//   handle store contents stay undefined, no clearing pass.
// ---------------------------------------------------------------------------
// weighted_class_packet_scheduler_unit
// Sorts packet handles into an urgent FIFO and six class FIFOs and serves
// send slots by strict priority, then by weighted class credits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module weighted_class_packet_scheduler_unit
  import wcps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [3:0]       weight [NUM_CLASSES];
  logic [3:0]       credit [NUM_CLASSES];
  logic [IDX_W-1:0] head   [NUM_QUEUES];
  logic [IDX_W-1:0] tail   [NUM_QUEUES];
  logic [CNT_W-1:0] fill   [NUM_QUEUES];
  logic [TOT_W-1:0] total;

  logic [3:0]       credit_next [NUM_CLASSES];
  logic [IDX_W-1:0] head_next   [NUM_QUEUES];
  logic [IDX_W-1:0] tail_next   [NUM_QUEUES];
  logic [CNT_W-1:0] fill_next   [NUM_QUEUES];
  logic [TOT_W-1:0] total_next;

  logic             s1_valid;
  logic [2:0]       s1_status;
  logic [2:0]       s1_qnum;
  logic             s1_send;
  logic [TOT_W-1:0] s1_total;

  logic [2:0]       dec_status;
  logic [2:0]       dec_qnum;
  logic             dec_send;

  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [HANDLE_WIDTH-1:0] ram_wdata;
  logic [HANDLE_WIDTH-1:0] ram_rdata;

  logic             in_accept;
  logic             advance;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;
  logic [TOT_W-1:0] fill_sum;

  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // -------------------------------------------------------------------------
  // Configuration port
  // -------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    prdata = '0;
    if (cfg_idx <= REG_WEIGHT_MISC) begin
      prdata[3:0] = weight[cfg_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= WEIGHT_RESET;
    end else if (cfg_wr && cfg_idx <= REG_WEIGHT_MISC) begin
      weight[cfg_idx] <= pwdata[3:0];
    end
  end

  // -------------------------------------------------------------------------
  // Classification and send selection
  // -------------------------------------------------------------------------
  function automatic logic [3:0] classify(logic [3:0] kind, logic [7:0] ttl, logic [7:0] hops);
    logic       is_local;
    logic [3:0] q;
    is_local = (ttl == 8'd1) && (hops == 8'd0);
    unique case (kind)
      KIND_PING:       q = {1'b0, is_local ? Q_URGENT : Q_PING};
      KIND_PONG:       q = {1'b0, is_local ? Q_URGENT : Q_PONG};
      KIND_BYE:        q = {1'b0, Q_URGENT};
      KIND_ROUTE,
      KIND_VENDOR,
      KIND_VENDOR_STD: q = {1'b0, Q_MISC};
      KIND_PUSH:       q = {1'b0, Q_PUSH};
      KIND_QUERY:      q = {1'b0, is_local ? Q_PUSH : Q_QUERY};
      KIND_HIT:        q = {1'b0, Q_QUERY_HIT};
      default:         q = 4'b1000;
    endcase
    return q;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_inc(logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(logic [2:0] q, logic [IDX_W-1:0] idx);
    return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(idx);
  endfunction

  logic [3:0] tgt;
  logic [2:0] tq;
  logic       found_credit;
  logic       found_any;
  logic [2:0] pick_credit;
  logic [2:0] pick_any;
  logic [2:0] sq;

  always_comb begin
    tgt = classify(in_item.msg_kind, in_item.ttl, in_item.hops);
    tq  = tgt[2:0];

    found_credit = 1'b0;
    found_any    = 1'b0;
    pick_credit  = '0;
    pick_any     = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (!found_credit && credit[i] != 4'd0 && fill[i+1] != '0) begin
        found_credit = 1'b1;
        pick_credit  = 3'(i);
      end
      if (!found_any && fill[i+1] != '0) begin
        found_any = 1'b1;
        pick_any  = 3'(i);
      end
    end
    sq = found_credit ? pick_credit : pick_any;

    credit_next = credit;
    head_next   = head;
    tail_next   = tail;
    fill_next   = fill;
    total_next  = total;
    dec_status  = ST_EMPTY;
    dec_qnum    = Q_URGENT;
    dec_send    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = '0;
    ram_wdata   = hnd_from_port(in_item.packet_handle);

    if (in_accept) begin
      if (in_item.cmd == CMD_ENQUEUE) begin
        if (tgt[3]) begin
          dec_status = ST_INVALID;
        end else if (fill[tq] == CNT_W'(QUEUE_DEPTH)) begin
          dec_status = ST_FULL;
          dec_qnum   = tq;
        end else begin
          ram_we        = 1'b1;
          ram_addr      = store_addr(tq, tail[tq]);
          tail_next[tq] = wrap_inc(tail[tq]);
          fill_next[tq] = fill[tq] + 1'b1;
          total_next    = total + 1'b1;
          dec_status    = ST_ENQUEUED;
          dec_qnum      = tq;
        end
      end else if (total == '0) begin
        dec_status = ST_EMPTY;
      end else if (fill[0] != '0) begin
        ram_re       = 1'b1;
        ram_addr     = store_addr(Q_URGENT, head[0]);
        head_next[0] = wrap_inc(head[0]);
        fill_next[0] = fill[0] - 1'b1;
        total_next   = total - 1'b1;
        dec_status   = ST_SENT;
        dec_send     = 1'b1;
      end else if (found_credit || found_any) begin
        // Reload every class before charging when no non-empty class has credit left.
        if (!found_credit) begin
          for (int i = 0; i < NUM_CLASSES; i++) begin
            credit_next[i] = (weight[i] == 4'd0) ? 4'd1 : weight[i];
          end
        end
        credit_next[sq] = credit_next[sq] - 1'b1;
        ram_re                = 1'b1;
        ram_addr              = store_addr(sq + 3'd1, head[sq + 3'd1]);
        head_next[sq + 3'd1]  = wrap_inc(head[sq + 3'd1]);
        fill_next[sq + 3'd1]  = fill[sq + 3'd1] - 1'b1;
        total_next            = total - 1'b1;
        dec_status            = ST_SENT;
        dec_qnum              = sq + 3'd1;
        dec_send              = 1'b1;
      end else begin
        dec_status = ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= WEIGHT_RESET;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
      total <= '0;
    end else begin
      credit <= credit_next;
      head   <= head_next;
      tail   <= tail_next;
      fill   <= fill_next;
      total  <= total_next;
    end
  end

  wcps_ram #(
    .WIDTH (HANDLE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // -------------------------------------------------------------------------
  // Decision register and output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_status <= dec_status;
      s1_qnum   <= dec_qnum;
      s1_send   <= dec_send;
      s1_total  <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.status          <= s1_status;
      out_item.queue_number    <= s1_qnum;
      out_item.handle_out      <= s1_send ? hnd_to_port(ram_rdata) : '0;
      out_item.packets_waiting <= tot_to_port(s1_total);
    end
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  always_comb begin
    fill_sum = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      fill_sum = fill_sum + TOT_W'(fill[i]);
    end
  end

  `WCPS_ASSERT_ALWAYS(a_total_matches_fill, clk, rst, total == fill_sum, "total count drifted from queue fills")
  `WCPS_ASSERT_NXT(a_accept_fills_s1, clk, rst, in_accept, s1_valid, "accepted item lost before decision register")
  `WCPS_ASSERT_NXT(a_urgent_first, clk, rst, in_accept && in_item.cmd == CMD_SEND && fill[0] != '0, s1_status == ST_SENT && s1_qnum == Q_URGENT, "urgent queue not served first")

endmodule

@@ rtl/core/wcps_ram.sv @@
// ---------------------------------------------------------------------------
// wcps_ram
// Generic single-port RAM with registered read; read data holds until the
// next read.
// ---------------------------------------------------------------------------
module wcps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 448
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
